/* rtl/core/mqtt_fixed_header_parser_assert.svh */
// Assertion macros for the MQTT fixed header parser.
// Each macro samples on the rising edge of the named clock and is disabled
// while the named active-low reset is asserted.
`ifndef MQTT_FIXED_HEADER_PARSER_ASSERT_SVH
`define MQTT_FIXED_HEADER_PARSER_ASSERT_SVH

// Check that a condition holds at every sampled edge.
`define MFHP_ASSERT_ALWAYS(label, clk_s, rst_n_s, cond, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (cond)) \
		else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define MFHP_ASSERT_SAME(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define MFHP_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mfhp_pkg.sv */
`timescale 1ns / 1ps
package mfhp_pkg;

	localparam int unsigned MaxLengthBytesDefault = 4;

	localparam int unsigned AccWidth = 28;
	localparam int unsigned CntWidth = 3;

	localparam logic [7:0] ContBit   = 8'h80;
	localparam logic [7:0] ValueMask = 8'h7f;
	localparam logic [3:0] TypeBad0  = 4'h0;
	localparam logic [3:0] TypeBad15 = 4'hf;

	typedef enum logic [3:0] {
		PH_TYPE = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_DONE = 4'b0100,
		PH_ERR  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ST_PENDING  = 3'd0,
		ST_COMPLETE = 3'd1,
		ST_BADTYPE  = 3'd2,
		ST_TOOLONG  = 3'd3,
		ST_PASSED   = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		status_t               status;
		logic [3:0]            packet_type;
		logic [3:0]            header_flags;
		logic [AccWidth-1:0]   remaining_length;
		logic [CntWidth-1:0]   length_byte_count;
	} result_t;

endpackage

/* rtl/core/mfhp_in_if.sv */
`timescale 1ns / 1ps
interface mfhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink (input valid, input data_byte, input restart, output ready);
endinterface

/* rtl/core/mfhp_out_if.sv */
`timescale 1ns / 1ps
interface mfhp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  packet_type;
	logic [3:0]  header_flags;
	logic [27:0] remaining_length;
	logic [2:0]  length_byte_count;

	modport source (
		output valid, output status, output packet_type, output header_flags,
		output remaining_length, output length_byte_count, input ready
	);
	modport sink (
		input valid, input status, input packet_type, input header_flags,
		input remaining_length, input length_byte_count, output ready
	);
endinterface

/* rtl/core/mfhp_in_reg.sv */
`timescale 1ns / 1ps
module mfhp_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	mfhp_in_if.sink           in_ch,
	input  logic              adv,
	output mfhp_pkg::in_item_t item_s1,
	output logic              valid_s1
);

	// Take a new item whenever the stage is empty or drains this cycle.
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.data_byte <= in_ch.data_byte;
			item_s1.restart   <= in_ch.restart;
		end
	end

endmodule

/* rtl/core/mfhp_step.sv */
`timescale 1ns / 1ps
`include "mqtt_fixed_header_parser_assert.svh"
module mfhp_step #(
	parameter int unsigned MAX_LENGTH_BYTES = mfhp_pkg::MaxLengthBytesDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  mfhp_pkg::in_item_t item_s1,
	output mfhp_pkg::result_t  res
);

	mfhp_pkg::phase_t                    phase_q, phase_d, phase_eff;
	logic [3:0]                          type_q, type_d;
	logic [3:0]                          flags_q, flags_d;
	logic [mfhp_pkg::AccWidth-1:0]       acc_q, acc_d, acc_add;
	logic [mfhp_pkg::CntWidth-1:0]       cnt_q, cnt_d;
	logic [6:0]                          val7;
	logic [3:0]                          nib_hi;
	mfhp_pkg::status_t                   status;

	assign val7   = 7'(item_s1.data_byte & mfhp_pkg::ValueMask);
	assign nib_hi = item_s1.data_byte[7:4];

	// Place the seven value bits at the slot of this length byte.
	always_comb begin
		acc_add = '0;
		case (cnt_q[1:0])
			2'd0: acc_add[6:0]   = val7;
			2'd1: acc_add[13:7]  = val7;
			2'd2: acc_add[20:14] = val7;
			2'd3: acc_add[27:21] = val7;
			default: acc_add = '0;
		endcase
	end

	always_comb begin
		phase_eff = item_s1.restart ? mfhp_pkg::PH_TYPE : phase_q;
		phase_d   = phase_q;
		type_d    = type_q;
		flags_d   = flags_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		status    = mfhp_pkg::ST_PASSED;
		case (phase_eff)
			mfhp_pkg::PH_TYPE: begin
				type_d  = nib_hi;
				flags_d = item_s1.data_byte[3:0];
				acc_d   = '0;
				cnt_d   = '0;
				if (nib_hi == mfhp_pkg::TypeBad0 || nib_hi == mfhp_pkg::TypeBad15) begin
					status  = mfhp_pkg::ST_BADTYPE;
					phase_d = mfhp_pkg::PH_ERR;
				end else begin
					status  = mfhp_pkg::ST_PENDING;
					phase_d = mfhp_pkg::PH_LEN;
				end
			end
			mfhp_pkg::PH_LEN: begin
				acc_d = acc_q | acc_add;
				cnt_d = cnt_q + mfhp_pkg::CntWidth'(1);
				if ((item_s1.data_byte & mfhp_pkg::ContBit) == 8'h00) begin
					status  = mfhp_pkg::ST_COMPLETE;
					phase_d = mfhp_pkg::PH_DONE;
				end else if (cnt_d >= mfhp_pkg::CntWidth'(MAX_LENGTH_BYTES)) begin
					status  = mfhp_pkg::ST_TOOLONG;
					phase_d = mfhp_pkg::PH_ERR;
				end else begin
					status = mfhp_pkg::ST_PENDING;
				end
			end
			default: begin
				// Complete or error: hold everything until a restart.
				status = mfhp_pkg::ST_PASSED;
			end
		endcase
	end

	assign res.status            = status;
	assign res.packet_type       = type_d;
	assign res.header_flags      = flags_d;
	assign res.remaining_length  = acc_d;
	assign res.length_byte_count = cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mfhp_pkg::PH_TYPE;
			type_q  <= '0;
			flags_q <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			flags_q <= flags_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
		end
	end

	`MFHP_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= mfhp_pkg::CntWidth'(MAX_LENGTH_BYTES), "length byte count beyond limit")
	`MFHP_ASSERT_NEXT(a_complete_done, clk, arst_n, adv && status == mfhp_pkg::ST_COMPLETE, phase_q == mfhp_pkg::PH_DONE, "complete header did not enter done phase")
	`MFHP_ASSERT_NEXT(a_pass_holds, clk, arst_n, adv && !item_s1.restart && (phase_q == mfhp_pkg::PH_DONE || phase_q == mfhp_pkg::PH_ERR), $stable(acc_q) && $stable(cnt_q) && $stable(type_q), "state changed while passing bytes over")

endmodule

/* rtl/core/mqtt_fixed_header_parser.sv */
// MQTT fixed header parser. Feed the message stream one byte per item on
// in_ch; every byte yields exactly one status item on out_ch, in order. The
// first byte (or any byte with restart set) is the type byte: type 1..14 gives
// status pending, type 0 or 15 gives bad type. Remaining-length bytes follow,
// base-128 little-endian, up to MAX_LENGTH_BYTES of them; the byte with its
// top bit clear gives complete with type, flags and full remaining_length, and
// a last allowed byte that still has the top bit set gives length too long.
// After complete or an error, bytes report passed over until a restart.
// Throughput is one byte per clock while the sink keeps taking status items.
// A byte taken from in_ch sits in the input register, passes the decode step
// and is loaded into the result register, from which its status item is
// offered on out_ch. A stalled sink holds the result register; the input
// register can still take one more byte, and only then does in_ch.ready drop.
// The result register lets a new byte be taken while a finished result still
// waits for the sink.
`timescale 1ns / 1ps
`include "mqtt_fixed_header_parser_assert.svh"
module mqtt_fixed_header_parser #(
	parameter int unsigned MAX_LENGTH_BYTES = mfhp_pkg::MaxLengthBytesDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	mfhp_in_if.sink    in_ch,
	mfhp_out_if.source out_ch
);

	mfhp_pkg::in_item_t item_s1;
	logic               valid_s1;
	mfhp_pkg::result_t  res;
	mfhp_pkg::result_t  res_q;
	logic               out_valid_q;
	logic               out_load;
	logic               adv;

	// Load the result register when it is empty or being drained this cycle.
	assign out_load = !out_valid_q || out_ch.ready;
	// Advance the parser state only when a byte moves into the result register.
	assign adv = valid_s1 && out_load;

	mfhp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.adv      (adv),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	mfhp_step #(
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item_s1 (item_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	// Hold the payload while the sink stalls.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.status            = res_q.status;
	assign out_ch.packet_type       = res_q.packet_type;
	assign out_ch.header_flags      = res_q.header_flags;
	assign out_ch.remaining_length  = res_q.remaining_length;
	assign out_ch.length_byte_count = res_q.length_byte_count;

	`MFHP_ASSERT_SAME(a_stall_blocks_in, clk, arst_n, valid_s1 && out_valid_q && !out_ch.ready, !in_ch.ready, "input taken while both stages are full and stalled")
	`MFHP_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, adv, out_valid_q, "advanced item did not reach the result register")

endmodule
